// ----- rtl/pce_pkg.sv -----
package pce_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_BITS_DEF = 32;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int LEN_FIELD_W  = 6;
  localparam int CODE_FIELD_W = 32;
  localparam int PEND_W     = BYTE_W - 1;  // leftover bits never reach a full byte

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [BYTE_W-1:0]       data_byte;
    logic [BYTE_W-1:0]       table_index;
    logic [LEN_FIELD_W-1:0]  code_length;
    logic [CODE_FIELD_W-1:0] code_bits;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_run;
    logic              end_of_message;
  } out_t;

endpackage

// ----- rtl/pce_emit.sv -----
module pce_emit #(
  parameter int WORD_W = 39,
  parameter int CNT_W  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [WORD_W-1:0] load_word,
  input  logic [CNT_W-1:0]  load_cnt,
  input  logic              load_eom,
  output logic              free,
  output logic              pkt_valid,
  input  logic              pkt_ready,
  output pce_pkg::out_t     pkt
);
  import pce_pkg::*;

  logic [WORD_W-1:0]  word;
  logic [CNT_W-1:0]   cnt;
  logic               eom;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W+2:0]   shamt;
  logic [WORD_W-1:0]  shifted;
  logic               last;

  assign cnt_dec   = cnt - CNT_W'(1);
  assign shamt     = {cnt_dec, 3'b000};
  assign shifted   = word >> shamt;
  assign last      = (cnt == CNT_W'(1));
  assign pkt_valid = (cnt != '0);
  assign free      = (cnt == '0) || (last && pkt_ready);

  // bytes leave most significant first
  assign pkt.out_byte       = shifted[BYTE_W-1:0];
  assign pkt.end_of_run     = last;
  assign pkt.end_of_message = last && eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (pkt_valid && pkt_ready) begin
      cnt <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
      eom  <= load_eom;
    end
  end

endmodule

// ----- rtl/prefix_code_byte_encoder.sv -----
// Prefix-code byte encoder. A load item (op 0) writes the code length and code
// bits of one symbol into the code table; lengths above MAX_CODE_BITS saturate.
// An encode item (op 1) looks up its byte, appends the low code_length bits MSB
// first to a bit accumulator and sends every completed byte, first code bit in
// bit 7. A finish item (op 2) flushes a partial byte padded with zeros, then
// sends a trailer byte holding the pad count (zero when aligned). end_of_run
// marks the last byte of each item, end_of_message the trailer. Load, op 3 and
// encodes that complete no byte send nothing. Timing: the table is one
// synchronous RAM written and read at the input handshake; its registered
// read data feeds the packing stage in the next cycle, which loads the output
// register, so an item's first byte reaches the output through the read data
// register and then the output register. Items are taken one per cycle as
// long as the output keeps up; the output register sends one byte per cycle
// while pkt_ready is high, and a following item that also sends bytes waits in
// the packing stage, with back-pressure on the input, until the last byte of
// the item before it is taken. Reading a symbol never loaded since reset gives
// undefined bytes.
module prefix_code_byte_encoder #(
  parameter int TABLE_ENTRIES = pce_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = pce_pkg::MAX_CODE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pce_pkg::in_t   cmd,
  output logic           pkt_valid,
  input  logic           pkt_ready,
  output pce_pkg::out_t  pkt
);
  import pce_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int CODE_W = (MAX_CODE_BITS < CODE_FIELD_W) ? MAX_CODE_BITS : CODE_FIELD_W;
  localparam int ENT_W  = LEN_W + CODE_W;
  localparam int ACC_W  = MAX_CODE_BITS + PEND_W;
  localparam int WORD_W = (ACC_W > 2 * BYTE_W) ? ACC_W : 2 * BYTE_W;
  localparam int CNT_W  = $clog2(WORD_W / BYTE_W + 1);
  localparam int TOT_W  = $clog2(ACC_W + 1);

  // ---------------------------------------------------------------- input side
  logic accept;
  logic idx_ok;
  logic sym_ok;
  logic len_over;
  logic [LEN_W-1:0] len_in;

  assign accept   = cmd_valid && cmd_ready;
  assign idx_ok   = ({1'b0, cmd.table_index} < 9'(TABLE_ENTRIES));
  assign sym_ok   = ({1'b0, cmd.data_byte} < 9'(TABLE_ENTRIES));
  assign len_over = ({1'b0, cmd.code_length} > 7'(MAX_CODE_BITS));
  assign len_in   = len_over ? LEN_W'(MAX_CODE_BITS) : LEN_W'(cmd.code_length);

  // Code table: {length, code} per symbol. Writes and reads both happen at
  // the input handshake, so a load is always in the RAM before any later
  // encode reads it; no bypass needed.
  logic [ENT_W-1:0] tbl [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_ent;

  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_LOAD && idx_ok) begin
      tbl[cmd.table_index[IDX_W-1:0]] <= {len_in, cmd.code_bits[CODE_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_ENCODE) begin
      rd_ent <= tbl[cmd.data_byte[IDX_W-1:0]];
    end
  end

  // ------------------------------------------------------------ packing stage
  logic            s1_valid;
  logic [OP_W-1:0] s1_op;
  logic            s1_sym_ok;
  logic [PEND_W-1:0] pend_bits;
  logic [2:0]        pend_cnt;

  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len_e;
  logic [ACC_W-1:0]  code_m;
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic [2:0]        rem;
  logic [CNT_W-1:0]  enc_cnt;
  logic [WORD_W-1:0] enc_word;
  logic [PEND_W-1:0] enc_pend;
  logic [3:0]        pad;
  logic [BYTE_W-1:0] pad_byte;
  logic [BYTE_W-1:0] flush_byte;

  logic              need_emit;
  logic              emit_free;
  logic              s1_adv;
  logic              emit_load;
  logic [WORD_W-1:0] emit_word;
  logic [CNT_W-1:0]  emit_cnt;
  logic              emit_eom;

  assign len_raw = rd_ent[ENT_W-1 -: LEN_W];

  always_comb begin
    if (!s1_sym_ok) begin
      len_e = '0;
    end else if (len_raw > LEN_W'(MAX_CODE_BITS)) begin
      len_e = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_e = len_raw;
    end
  end

  // accumulate: leftover bits above the new code, then split off whole bytes
  assign code_m   = ACC_W'(rd_ent[CODE_W-1:0]) & ~({ACC_W{1'b1}} << len_e);
  assign acc      = (ACC_W'(pend_bits) << len_e) | code_m;
  assign total    = TOT_W'(pend_cnt) + TOT_W'(len_e);
  assign rem      = total[2:0];
  assign enc_cnt  = CNT_W'(total >> 3);
  assign enc_word = WORD_W'(acc >> rem);
  assign enc_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);

  // finish: pad count and the zero-padded partial byte
  assign pad        = 4'(BYTE_W) - {1'b0, pend_cnt};
  assign pad_byte   = BYTE_W'(pad);
  assign flush_byte = BYTE_W'({1'b0, pend_bits} << pad);

  always_comb begin
    need_emit = 1'b0;
    emit_word = enc_word;
    emit_cnt  = enc_cnt;
    emit_eom  = 1'b0;
    case (s1_op)
      OP_ENCODE: begin
        need_emit = (enc_cnt != '0);
      end
      OP_FINISH: begin
        need_emit = 1'b1;
        emit_eom  = 1'b1;
        if (pend_cnt != 3'd0) begin
          emit_word = WORD_W'({flush_byte, pad_byte});
          emit_cnt  = CNT_W'(2);
        end else begin
          emit_word = '0;
          emit_cnt  = CNT_W'(1);
        end
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign s1_adv    = s1_valid && (!need_emit || emit_free);
  assign emit_load = s1_adv && need_emit;
  assign cmd_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= cmd.op;
      s1_sym_ok <= sym_ok;
    end
  end

  // leftover bits are updated as the item leaves the packing stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (s1_adv && s1_op == OP_ENCODE) begin
      pend_bits <= enc_pend;
      pend_cnt  <= rem;
    end else if (s1_adv && s1_op == OP_FINISH) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end
  end

  // ------------------------------------------------------------- output side
  pce_emit #(
    .WORD_W (WORD_W),
    .CNT_W  (CNT_W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_word (emit_word),
    .load_cnt  (emit_cnt),
    .load_eom  (emit_eom),
    .free      (emit_free),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

endmodule
